@@ src/sha_pkg.sv @@
// Shared definitions for the SHA-256 byte-stream hasher: round constants,
// initial hash value, a rotate helper and the datapath control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumHash = 8;
  localparam int unsigned PadLenAt = 56;
  localparam logic [7:0]  PadMarker = 8'h80;

  typedef logic [WordW-1:0] word_t;

  // Control from the sequencer to the compression datapath.
  typedef struct packed {
    logic       w_shift;     // advance the schedule window
    logic       w_from_mem;  // new window word comes from the block buffer
    logic       v_load;      // load working word v_idx from the hash store
    logic       v_add;       // add the hash store word into working word v_idx
    logic [2:0] v_idx;
    logic       round;       // run one compression round
    logic [5:0] t;           // round number
  } sha_ctl_t;

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t iv(input logic [2:0] idx);
    case (idx)
      3'd0:    iv = 32'h6a09e667;
      3'd1:    iv = 32'hbb67ae85;
      3'd2:    iv = 32'h3c6ef372;
      3'd3:    iv = 32'ha54ff53a;
      3'd4:    iv = 32'h510e527f;
      3'd5:    iv = 32'h9b05688c;
      3'd6:    iv = 32'h1f83d9ab;
      default: iv = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ src/sha_msg_ram.sv @@
// Block buffer: 16 x 32-bit memory, byte-wide writes, registered word reads.
// Bytes are stored big-endian within a word. Uses sha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha_msg_ram (
  input  wire               clk,
  input  wire               wr_en,
  input  wire  [5:0]        wr_addr,
  input  wire  [7:0]        wr_data,
  input  wire  [3:0]        rd_addr,
  output sha_pkg::word_t    rd_data
);

  sha_pkg::word_t mem_r [16];
  sha_pkg::word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ src/sha_hash_ram.sv @@
// Running hash store: 8 x 32-bit memory with registered reads and a valid
// bit per entry; an entry not yet written reads as the initial hash.
// Uses sha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha_hash_ram (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    clr,
  input  wire                    wr_en,
  input  wire  [2:0]             wr_addr,
  input  wire  sha_pkg::word_t   wr_data,
  input  wire  [2:0]             rd_addr,
  output sha_pkg::word_t         rd_data
);

  sha_pkg::word_t mem_r [sha_pkg::NumHash];
  sha_pkg::word_t mem_q_r;
  logic [sha_pkg::NumHash-1:0] valid_r;
  logic [2:0] rd_addr_r;
  logic       rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    mem_q_r   <= mem_r[rd_addr];
    rd_addr_r <= rd_addr;
    rd_vld_r  <= valid_r[rd_addr];
  end

  // Clearing the valid bits restores the initial hash.
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? mem_q_r : sha_pkg::iv(rd_addr_r);

endmodule

`default_nettype wire

@@ src/sha_compress.sv @@
// Compression datapath: eight working words, the 16-word message schedule
// window and the round logic, one round per cycle while ctl.round is set. Uses sha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sha_compress (
  input  wire                      clk,
  input  wire  sha_pkg::sha_ctl_t  ctl,
  input  wire  sha_pkg::word_t     msg_word,
  input  wire  sha_pkg::word_t     hash_word,
  output sha_pkg::word_t           sum_word,
  input  wire  [2:0]               out_idx,
  output sha_pkg::word_t           out_word
);

  sha_pkg::word_t v_r [sha_pkg::NumHash];
  sha_pkg::word_t w_r [16];

  sha_pkg::word_t w_new, big_s0, big_s1, ch, maj, t1, sm_s0, sm_s1;

  always_comb begin
    sm_s0 = sha_pkg::ror(w_r[1], 7) ^ sha_pkg::ror(w_r[1], 18) ^ (w_r[1] >> 3);
    sm_s1 = sha_pkg::ror(w_r[14], 17) ^ sha_pkg::ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + sm_s0 + w_r[9] + sm_s1;

    big_s1 = sha_pkg::ror(v_r[4], 6) ^ sha_pkg::ror(v_r[4], 11) ^ sha_pkg::ror(v_r[4], 25);
    ch     = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1     = v_r[7] + big_s1 + ch + sha_pkg::round_k(ctl.t) + w_r[0];
    big_s0 = sha_pkg::ror(v_r[0], 2) ^ sha_pkg::ror(v_r[0], 13) ^ sha_pkg::ror(v_r[0], 22);
    maj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  end

  assign sum_word = hash_word + v_r[ctl.v_idx];
  assign out_word = v_r[out_idx];

  always_ff @(posedge clk) begin
    if (ctl.w_shift) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= ctl.w_from_mem ? msg_word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.v_load) begin
      v_r[ctl.v_idx] <= hash_word;
    end else if (ctl.v_add) begin
      v_r[ctl.v_idx] <= sum_word;
    end else if (ctl.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + big_s0 + maj;
    end
  end

endmodule

`default_nettype wire

@@ src/sha256_stream_hasher_top.sv @@
// Top level of the SHA-256 byte-stream hasher: sequencer, length counter and
// handshakes. Depends on sha_pkg, sha_msg_ram, sha_hash_ram, sha_compress.
//
//   Channel | Ports                                             | Direction
//   --------+---------------------------------------------------+----------
//   input   | in_valid/in_ready, in_data_byte, in_byte_present,  | in
//           | in_end_of_message                                 |
//   result  | out_valid/out_ready, out_digest_word,             | out
//           | out_word_index, out_last_word                     |
//
// A byte beat that neither completes a block nor ends the message leaves the
// sequencer idle. The beat that fills a 64-byte block starts a compression: a
// load phase reads the block and hash words out of the memories, 64 rounds run
// on the single round unit, and a write-back phase adds and writes back the
// hash. An end beat writes the padding one byte per cycle through the block
// buffer's write port (up to 72 bytes), runs one or two compressions, then
// presents the eight digest beats; out_ready stalls hold the digest in place.
// Only one beat is in work at a time: in_ready is high only while the sequencer
// is idle. Reset is synchronous and leaves the block ready for a new message
// with the initial hash; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher_top (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire  [7:0]   in_data_byte,
  input  wire          in_byte_present,
  input  wire          in_end_of_message,
  output logic         out_valid,
  input  wire          out_ready,
  output logic [31:0]  out_digest_word,
  output logic [2:0]   out_word_index,
  output logic         out_last_word
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_WB    = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic        end_pend_r, end_pend_nxt;   // an end beat is being finished
  logic        marker_r, marker_nxt;       // the 0x80 marker has been written
  logic        len_blk_r, len_blk_nxt;     // the current pad block holds the length
  logic        final_r, final_nxt;         // the running compression is the last one

  logic        in_acc, out_acc;
  logic        len_now;
  logic [7:0]  pad_byte;

  logic        msg_we;
  logic [5:0]  msg_waddr;
  logic [7:0]  msg_wdata;
  logic [3:0]  msg_raddr;
  sha_pkg::word_t msg_rdata;

  logic        hash_we, hash_clr;
  logic [2:0]  hash_waddr, hash_raddr;
  sha_pkg::word_t hash_rdata, hash_sum;

  sha_pkg::sha_ctl_t ctl;
  sha_pkg::word_t    digest_word;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_acc   = out_valid && out_ready;

  assign out_word_index  = cnt_r[2:0];
  assign out_last_word   = (cnt_r[2:0] == 3'd7);
  assign out_digest_word = digest_word;

  // Length bytes go out most significant first at byte positions 56..63.
  assign len_now  = marker_r ? len_blk_r : (fill_r < 6'(sha_pkg::PadLenAt));
  assign pad_byte = !marker_r ? sha_pkg::PadMarker :
                    (len_blk_r && fill_r >= 6'(sha_pkg::PadLenAt)) ?
                    8'(bits_r >> {~fill_r[2:0], 3'b000}) : 8'h00;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    fill_nxt     = fill_r;
    bits_nxt     = bits_r;
    end_pend_nxt = end_pend_r;
    marker_nxt   = marker_r;
    len_blk_nxt  = len_blk_r;
    final_nxt    = final_r;

    msg_we     = 1'b0;
    msg_waddr  = fill_r;
    msg_wdata  = pad_byte;
    msg_raddr  = cnt_r[3:0];
    hash_we    = 1'b0;
    hash_clr   = 1'b0;
    hash_waddr = 3'(cnt_r - 7'd1);
    hash_raddr = cnt_r[2:0];

    ctl            = '0;
    ctl.t          = cnt_r[5:0];
    ctl.v_idx      = 3'(cnt_r - 7'd1);

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          end_pend_nxt = in_end_of_message;
          marker_nxt   = 1'b0;
          final_nxt    = 1'b0;
          if (in_byte_present) begin
            msg_we    = 1'b1;
            msg_wdata = in_data_byte;
            fill_nxt  = fill_r + 6'd1;
            bits_nxt  = bits_r + 64'd8;
          end
          cnt_nxt = '0;
          if (in_byte_present && fill_r == 6'd63) begin
            state_nxt = S_LOAD;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        msg_we     = 1'b1;
        fill_nxt   = fill_r + 6'd1;
        marker_nxt = 1'b1;
        if (!marker_r) begin
          len_blk_nxt = len_now;
        end
        if (fill_r == 6'd63) begin
          final_nxt   = len_now;
          len_blk_nxt = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        // Reads issued at cnt, data captured at cnt + 1.
        ctl.w_shift    = (cnt_r != 7'd0);
        ctl.w_from_mem = 1'b1;
        ctl.v_load     = (cnt_r != 7'd0) && (cnt_r <= 7'd8);
        cnt_nxt        = cnt_r + 7'd1;
        if (cnt_r == 7'd16) begin
          cnt_nxt   = '0;
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        ctl.round   = 1'b1;
        ctl.w_shift = 1'b1;
        cnt_nxt     = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          cnt_nxt   = '0;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        // Read of entry j overlaps the write of entry j - 1, never the same one.
        ctl.v_add = (cnt_r != 7'd0);
        hash_we   = (cnt_r != 7'd0);
        cnt_nxt   = cnt_r + 7'd1;
        if (cnt_r == 7'd8) begin
          cnt_nxt = '0;
          if (final_r) begin
            state_nxt = S_OUT;
          end else if (end_pend_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_acc) begin
          cnt_nxt = cnt_r + 7'd1;
          if (out_last_word) begin
            hash_clr     = 1'b1;
            cnt_nxt      = '0;
            fill_nxt     = '0;
            bits_nxt     = '0;
            end_pend_nxt = 1'b0;
            marker_nxt   = 1'b0;
            len_blk_nxt  = 1'b0;
            final_nxt    = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      fill_r     <= '0;
      bits_r     <= '0;
      end_pend_r <= 1'b0;
      marker_r   <= 1'b0;
      len_blk_r  <= 1'b0;
      final_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      fill_r     <= fill_nxt;
      bits_r     <= bits_nxt;
      end_pend_r <= end_pend_nxt;
      marker_r   <= marker_nxt;
      len_blk_r  <= len_blk_nxt;
      final_r    <= final_nxt;
    end
  end

  sha_msg_ram u_msg_ram (
    .clk     (clk),
    .wr_en   (msg_we),
    .wr_addr (msg_waddr),
    .wr_data (msg_wdata),
    .rd_addr (msg_raddr),
    .rd_data (msg_rdata)
  );

  sha_hash_ram u_hash_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (hash_clr),
    .wr_en   (hash_we),
    .wr_addr (hash_waddr),
    .wr_data (hash_sum),
    .rd_addr (hash_raddr),
    .rd_data (hash_rdata)
  );

  sha_compress u_compress (
    .clk       (clk),
    .ctl       (ctl),
    .msg_word  (msg_rdata),
    .hash_word (hash_rdata),
    .sum_word  (hash_sum),
    .out_idx   (cnt_r[2:0]),
    .out_word  (digest_word)
  );

  // A byte that completes a block always starts a compression.
  a_full_block_compresses: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_byte_present && fill_r == 6'd63 |=> state_r == S_LOAD)
    else $error("full block did not start compression");

  // The round phase ends at round 63 and hands over to write-back.
  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND && cnt_r == 7'd63 |=> state_r == S_WB && cnt_r == 7'd0)
    else $error("round phase did not hand over to write-back");

  // Padding only runs while an end beat is being finished.
  a_pad_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PAD |-> end_pend_r)
    else $error("padding without an end beat");

  // The last digest beat restarts the message state.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_last_word |=> state_r == S_IDLE && fill_r == 6'd0 && bits_r == 64'd0)
    else $error("message state not restarted after digest");

  // Digest beats are only shown after a final compression.
  a_out_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> final_r && end_pend_r)
    else $error("digest shown without a final compression");

endmodule

`default_nettype wire

@@ sim/sha256_digest_tracker_pkg.sv @@
// Digest tracker for the SHA-256 byte-stream hasher bench: a bit-exact software
// hash that follows every accepted beat and checks each digest word against it.
// Depends on sha_pkg for the padding marker and the length field offset.
`timescale 1ns / 1ps

package sha256_digest_tracker_pkg;

  typedef struct packed {
    bit [31:0] word;
    bit [2:0]  pos;
    bit        last;
  } digest_word_t;

  class sha256_digest_tracker;

    bit [31:0]    round_const[64];
    bit [31:0]    start_hash[8];
    bit [31:0]    chain[8];
    bit [7:0]     blk[64];
    int unsigned  fill;
    bit [63:0]    bit_count;
    digest_word_t pending_words[$];
    int unsigned  failures;
    int unsigned  words_checked;

    function new();
      round_const = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      start_hash = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      foreach (blk[i]) blk[i] = 8'h00;
      failures = 0;
      words_checked = 0;
      restart();
    endfunction

    local function void restart();
      chain = start_hash;
      fill = 0;
      bit_count = 64'd0;
    endfunction

    local function bit [31:0] rotr(bit [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of blk into the chaining value.
    local function void compress();
      bit [31:0] w[64];
      bit [31:0] v[8];
      bit [31:0] t1;
      bit [31:0] t2;
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
             + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
      v = chain;
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[i] + w[i];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // Notes one accepted input beat; an end beat queues the eight digest words.
    function void absorb_beat(bit [7:0] data, bit present, bit eom);
      digest_word_t dw;
      if (present) begin
        blk[fill] = data;
        fill++;
        bit_count += 64'd8;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!eom) return;
      blk[fill] = sha_pkg::PadMarker;
      fill++;
      // Too little room for the length: close this block and start another.
      if (fill > sha_pkg::PadLenAt) begin
        while (fill < 64) blk[fill++] = 8'h00;
        compress();
        fill = 0;
      end
      while (fill < sha_pkg::PadLenAt) blk[fill++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56 + i] = bit_count[63 - 8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        dw.word = chain[i];
        dw.pos  = 3'(i);
        dw.last = (i == 7);
        pending_words = {pending_words, dw};
      end
      restart();
    endfunction

    function void check_digest_word(bit [31:0] word, bit [2:0] pos, bit last);
      digest_word_t exp_w;
      if (pending_words.size() == 0) begin
        $error("unexpected digest beat: word %h index %0d last %0d", word, pos, last);
        failures++;
        return;
      end
      exp_w = pending_words.pop_front();
      words_checked++;
      if (word !== exp_w.word) begin
        $error("digest_word: expected %h, actual %h", exp_w.word, word);
        failures++;
      end
      if (pos !== exp_w.pos) begin
        $error("word_index: expected %0d, actual %0d", exp_w.pos, pos);
        failures++;
      end
      if (last !== exp_w.last) begin
        $error("last_word: expected %0d, actual %0d", exp_w.last, last);
        failures++;
      end
    endfunction

    function int unsigned words_outstanding();
      return pending_words.size();
    endfunction

  endclass

endpackage

@@ sim/tb_sha256_stream_hasher_top.sv @@
// Self-checking bench for sha256_stream_hasher_top: drives byte streams with
// random idling on both channels and checks every digest beat.
// Depends on sha_pkg, the hasher RTL and sha256_digest_tracker_pkg.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_top;

  // No beat accepted on either channel for this many cycles means a hang. The
  // slowest end beat writes up to 72 padding bytes and runs two compressions;
  // idle gaps at 81 percent rarely come near the limit.
  localparam int unsigned WatchdogLimit = 5000;
  // Quiet time after the last digest word, covering one full end beat.
  localparam int unsigned DrainCycles   = 400;
  // Input beats, directed ones included, after which no new message starts.
  localparam int unsigned RandomBeats   = 300;
  // Chance, in percent, of an ignored beat (no byte, no end) before a byte.
  localparam int unsigned NoisePct      = 8;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte      = 8'h00;
  logic        in_byte_present   = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_digest_tracker_pkg::sha256_digest_tracker tracker;

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned stall_cycles   = 0;
  int unsigned beats_sent     = 0;
  int unsigned message_beats  = 0;
  int unsigned messages_sent  = 0;
  int unsigned long_tails     = 0;
  int unsigned longest_msg    = 0;

  sha256_stream_hasher_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side. Outputs are sampled at the edge with their pre-edge values,
  // then out_ready for the next cycle is chosen with a single nonblocking
  // assignment. A stall holds the digest word in place inside the block.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_digest_word(out_digest_word, out_word_index, out_last_word);
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $error("watchdog: no beat accepted in %0d cycles", stall_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic set_idle_mode(input idle_mode_e mode);
    src_idle_pct   = (mode == IDLE_SENDER)   ? 81 :
                     (mode == IDLE_BOTH)     ? 7  : 0;
    sink_stall_pct = (mode == IDLE_RECEIVER) ? 81 :
                     (mode == IDLE_BOTH)     ? 7  : 0;
  endtask

  // Presents one input beat and returns at the edge that accepts it. The task
  // is always entered at a rising edge. If the sender idles, valid drops for
  // a geometric number of cycles; otherwise the new payload follows straight
  // on, so in_valid gets only one assignment per edge either way.
  task automatic send_beat(input bit [7:0] data, input bit present, input bit eom);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= data;
    in_byte_present   <= present;
    in_end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    tracker.absorb_beat(data, present, eom);
    beats_sent++;
  endtask

  // Mostly uniform bytes, with the all-zeros and all-ones values now and then.
  function automatic bit [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5)  return 8'h00;
    if (r < 10) return 8'hff;
    return 8'($urandom_range(255));
  endfunction

  // Sends one whole message of len bytes. The last byte rides on the end beat
  // half of the time; otherwise a bare end marker with a junk byte closes it.
  // Ignored beats are sprinkled in between and do not count as message beats.
  task automatic send_message(input int unsigned len);
    bit tail_on_end;
    tail_on_end = (len > 0) && ($urandom_range(1) == 1);
    for (int unsigned n = 0; n < len; n++) begin
      if ($urandom_range(99) < NoisePct) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(pick_byte(), 1'b1, tail_on_end && (n == len - 1));
      message_beats++;
    end
    if (!tail_on_end) begin
      send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
      message_beats++;
    end
    messages_sent++;
    if (len % 64 >= 56) long_tails++;
    if (len > longest_msg) longest_msg = len;
  endtask

  // Length mix: many short messages, many near the padding boundaries where
  // the length spills into a second block, and some random ones up to 130 bytes.
  function automatic int unsigned pick_length();
    int unsigned r;
    int unsigned near_edge[10];
    near_edge = '{0, 55, 56, 57, 62, 63, 64, 65, 119, 120};
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(9);
    if (r < 70) return near_edge[$urandom_range(9)];
    return $urandom_range(130);
  endfunction

  initial begin
    tracker = new();
    set_idle_mode(IDLE_NONE);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The empty message comes first, straight out of reset,
    // then again right after a digest to check that the hash restarts.
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b0, 1'b1);
    // Beats with neither flag set must leave the state alone.
    send_beat(8'ha5, 1'b0, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b0);
    // The classic three-byte message, closed with a bare end marker.
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    // A one-byte message whose byte rides on the end beat itself.
    send_beat(8'hff, 1'b1, 1'b1);
    // Extreme byte values with an ignored beat in the middle of the message.
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h80, 1'b1, 1'b1);
    messages_sent += 5;

    // Random part. The first message is forced into the long-tail range so
    // that the two-block padding is always seen; the idle mode steps through
    // all four settings as the beats go by.
    send_message(56 + $urandom_range(7));
    while (beats_sent < RandomBeats) begin
      set_idle_mode(idle_mode_e'((beats_sent * 4) / RandomBeats));
      send_message(pick_length());
    end
    in_valid <= 1'b0;

    while (tracker.words_outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Hashed %0d messages in %0d input beats (%0d random message beats), %0d %s",
             messages_sent, beats_sent, message_beats, long_tails,
             "of them with a two-block tail.");
    $display("Checked %0d digest words; longest message %0d bytes.",
             tracker.words_checked, longest_msg);
    if (tracker.failures == 0 && tracker.words_outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sha_pkg.sv
src/sha_msg_ram.sv
src/sha_hash_ram.sv
src/sha_compress.sv
src/sha256_stream_hasher_top.sv
sim/sha256_digest_tracker_pkg.sv
sim/tb_sha256_stream_hasher_top.sv
